// ===== rtl/efpb_pkg.sv =====
// ----------------------------------------------------------------------------
// efpb_pkg
// Shared types, constants and the normal cdf table for the profile builder.
// ----------------------------------------------------------------------------
package efpb_pkg;

	localparam int MAX_INTERFACES  = 16;
	localparam int MAX_PROFILES    = 4;
	localparam int CDF_TABLE_DEPTH = 256;
	localparam int CDF_SPAN        = 6;

	localparam logic [30:0] BLEND_ONE = 31'h4000_0000;
	localparam logic [18:0] T_SAT     = 19'd393216;

	typedef enum logic [1:0] {
		OP_LOAD_IFACE    = 2'd0,
		OP_LOAD_CONTRAST = 2'd1,
		OP_LOAD_BASE     = 2'd2,
		OP_EVALUATE      = 2'd3
	} opcode_t;

	typedef enum logic [0:0] {
		REG_NUM_INTERFACES = 1'b0,
		REG_NUM_PROFILES   = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_DIV,
		B_IDX,
		B_MUL,
		B_RCP
	} bstate_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BREQ,
		S_BWAIT,
		S_PSTART,
		S_PRD,
		S_PMUL,
		S_PACC,
		S_POUT
	} state_t;

	typedef struct packed {
		logic        start;
		logic [31:0] z;
		logic [31:0] off;
		logic [31:0] rough;
	} blend_req_t;

	typedef struct packed {
		logic        done;
		logic [30:0] blend;
	} blend_rsp_t;

	typedef logic [30:0] cdf_rom_t [0:CDF_TABLE_DEPTH];

	function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = a * b + 64'h2000_0000;
		return p >> 30;
	endfunction

	function automatic cdf_rom_t build_cdf();
		cdf_rom_t    rom;
		logic [63:0] s, x, x2, r, r2, w, g0, g1, g2, q, acc;
		int          k;
		s   = (64'(CDF_SPAN) << 30) / 64'(2 * CDF_TABLE_DEPTH);
		x   = (s * s) >> 31;
		x2  = (x * x) >> 30;
		r   = 64'h4000_0000 - x + (x2 >> 1) - ((x2 * x) >> 30) / 64'd6;
		r2  = mul_q30(r, r);
		w   = (64'd428361012 * 64'(CDF_SPAN)) / 64'(6 * CDF_TABLE_DEPTH);
		g0  = 64'h4000_0000;
		q   = r;
		acc = 64'h2000_0000;
		rom[0] = 31'(acc);
		for (k = 0; k < CDF_TABLE_DEPTH; k++) begin
			g1  = mul_q30(g0, q);
			q   = mul_q30(q, r2);
			g2  = mul_q30(g1, q);
			q   = mul_q30(q, r2);
			acc = acc + ((((g0 + 64'd4 * g1 + g2) * w) + 64'h2000_0000) >> 30);
			if (acc > 64'h4000_0000) begin
				acc = 64'h4000_0000;
			end
			rom[k + 1] = 31'(acc);
			g0 = g2;
		end
		return rom;
	endfunction

	localparam cdf_rom_t CDF_ROM = build_cdf();

endpackage

// ===== rtl/efpb_blend_unit.sv =====
// ----------------------------------------------------------------------------
// efpb_blend_unit
// Iterative blend of one interface: restoring divide, table interpolation.
// ----------------------------------------------------------------------------
module efpb_blend_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  efpb_pkg::blend_req_t req,
	output efpb_pkg::blend_rsp_t rsp
);

	efpb_pkg::bstate_t state_q, state_d;

	logic        neg_q;
	logic [48:0] rem_q;
	logic [48:0] dsh_q;
	logic [18:0] quo_q;
	logic [4:0]  cnt_q;
	logic [7:0]  idx_q;
	logic [10:0] frac_q;
	logic [30:0] lo_q;
	logic [40:0] y_q;
	logic [30:0] blend_q;
	logic        done_q;

	logic [32:0] diff;
	logic [32:0] mag;
	logic [48:0] mnum;
	logic [49:0] dlim;
	logic        sharp;
	logic        qbit;
	logic [19:0] hprod;
	logic [7:0]  idx_c;
	logic [18:0] frac_c;
	logic [30:0] cdiff;
	logic [63:0] rprod;
	logic [30:0] vsum;

	assign diff  = {req.z[31], req.z} - {req.off[31], req.off};
	assign mag   = diff[32] ? (33'd0 - diff) : diff;
	assign mnum  = {mag, 16'd0};
	assign dlim  = {req.rough[30:0], 19'd0};
	assign sharp = req.rough[31] || (req.rough == 32'd0);
	assign qbit  = (rem_q >= dsh_q);
	assign hprod = 20'(quo_q[18:9] * 10'd683);
	assign idx_c = hprod[18:11];
	assign frac_c = quo_q - ({1'b0, idx_c, 10'd0} + {2'd0, idx_c, 9'd0});
	assign cdiff = efpb_pkg::CDF_ROM[9'(idx_q) + 9'd1] - efpb_pkg::CDF_ROM[9'(idx_q)];
	assign rprod = {32'd0, y_q[40:9]} * 64'h0000_0000_AAAA_AAAB;
	assign vsum  = lo_q + rprod[63:33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efpb_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			efpb_pkg::B_IDLE: begin
				if (req.start && !sharp && ({1'b0, mnum} < dlim)) begin
					state_d = efpb_pkg::B_DIV;
				end
			end
			efpb_pkg::B_DIV: begin
				if (cnt_q == 5'd0) begin
					state_d = efpb_pkg::B_IDX;
				end
			end
			efpb_pkg::B_IDX: begin
				state_d = (quo_q >= efpb_pkg::T_SAT) ? efpb_pkg::B_IDLE : efpb_pkg::B_MUL;
			end
			efpb_pkg::B_MUL: state_d = efpb_pkg::B_RCP;
			efpb_pkg::B_RCP: state_d = efpb_pkg::B_IDLE;
			default: state_d = efpb_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				efpb_pkg::B_IDLE: begin
					if (req.start && (sharp || ({1'b0, mnum} >= dlim))) begin
						done_q <= 1'b1;
					end
				end
				efpb_pkg::B_IDX: done_q <= (quo_q >= efpb_pkg::T_SAT);
				efpb_pkg::B_RCP: done_q <= 1'b1;
				default: done_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			efpb_pkg::B_IDLE: begin
				neg_q <= diff[32];
				rem_q <= mnum;
				dsh_q <= {req.rough[30:0], 18'd0};
				quo_q <= 19'd0;
				cnt_q <= 5'd18;
				blend_q <= diff[32] ? 31'd0 : efpb_pkg::BLEND_ONE;
			end
			efpb_pkg::B_DIV: begin
				if (qbit) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[17:0], qbit};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 5'd1;
			end
			efpb_pkg::B_IDX: begin
				idx_q  <= idx_c;
				frac_q <= frac_c[10:0];
				blend_q <= neg_q ? 31'd0 : efpb_pkg::BLEND_ONE;
			end
			efpb_pkg::B_MUL: begin
				lo_q <= efpb_pkg::CDF_ROM[9'(idx_q)];
				y_q  <= 41'(cdiff * frac_q);
			end
			efpb_pkg::B_RCP: begin
				blend_q <= neg_q ? (efpb_pkg::BLEND_ONE - vsum) : vsum;
			end
			default: blend_q <= blend_q;
		endcase
	end

	assign rsp.done  = done_q;
	assign rsp.blend = blend_q;

endmodule

// ===== rtl/error_function_profile_builder.sv =====
// ----------------------------------------------------------------------------
// error_function_profile_builder
// Depth profiles as sums of smoothed steps, one result per profile.
//
//  channel  | signals                                        | role
//  item     | item_valid/item_ready, opcode .. roughness     | loads, evaluate
//  result   | result_valid/result_ready, profile_number ..   | profile values
//  config   | cfg_write, cfg_index, cfg_data                 | register writes
//
// loads complete when accepted; an evaluate runs each interface through the
// blend unit (19-step divider, then table lookup, skipped for a sharp or
// out-of-span step), then sums every interface for each profile, one profile value at a time
// reset clears control state only; stores hold garbage until loaded
// a stalled result holds the sequencer until transferred
// ----------------------------------------------------------------------------
module error_function_profile_builder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [0:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  opcode,
	input  logic [3:0]  interface_index,
	input  logic [1:0]  profile_index,
	input  logic signed [31:0] position_or_value,
	input  logic signed [31:0] roughness_value,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  profile_number,
	output logic signed [31:0] profile_value,
	output logic        last_result
);

	efpb_pkg::state_t state_q, state_d;

	logic [4:0]  num_if_q;
	logic [2:0]  num_pr_q;
	logic [4:0]  ni;
	logic [2:0]  np;

	logic [31:0] off_q   [0:15];
	logic [31:0] rough_q [0:15];
	logic [31:0] base_q  [0:3];
	logic [31:0] cmem    [0:63];
	logic [31:0] cdata_q;
	logic [30:0] blend_q [0:15];

	logic [31:0] z_q;
	logic [4:0]  i_q;
	logic [2:0]  p_q;
	logic signed [63:0] prod_q;
	logic signed [37:0] sum_q;
	logic signed [33:0] term;
	logic signed [31:0] sat;
	logic        out_free;
	logic        accept;

	efpb_pkg::blend_req_t breq;
	efpb_pkg::blend_rsp_t brsp;

	assign ni = (num_if_q > 5'd16) ? 5'd16 : num_if_q;
	assign np = (num_pr_q == 3'd0) ? 3'd1 : ((num_pr_q > 3'd4) ? 3'd4 : num_pr_q);

	assign item_ready = (state_q == efpb_pkg::S_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !result_valid || result_ready;

	assign breq.start = (state_q == efpb_pkg::S_BREQ);
	assign breq.z     = z_q;
	assign breq.off   = off_q[i_q[3:0]];
	assign breq.rough = rough_q[i_q[3:0]];

	efpb_blend_unit u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (breq),
		.rsp    (brsp)
	);

	assign term = 34'((prod_q + 64'sh2000_0000) >>> 30);
	assign sat  = (sum_q > 38'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
	              ((sum_q < -38'sh0_8000_0000) ? 32'sh8000_0000 : 32'(sum_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_if_q <= 5'd0;
			num_pr_q <= 3'd1;
		end else if (cfg_write) begin
			unique case (efpb_pkg::reg_index_t'(cfg_index))
				efpb_pkg::REG_NUM_INTERFACES: num_if_q <= cfg_data;
				efpb_pkg::REG_NUM_PROFILES:   num_pr_q <= cfg_data[2:0];
				default: num_if_q <= num_if_q;
			endcase
		end
	end

	// stores
	always_ff @(posedge clk) begin
		if (accept) begin
			case (efpb_pkg::opcode_t'(opcode))
				efpb_pkg::OP_LOAD_IFACE: begin
					off_q[interface_index]   <= position_or_value;
					rough_q[interface_index] <= roughness_value;
				end
				efpb_pkg::OP_LOAD_CONTRAST: cmem[{profile_index, interface_index}] <= position_or_value;
				efpb_pkg::OP_LOAD_BASE:     base_q[profile_index] <= position_or_value;
				default: z_q <= position_or_value;
			endcase
		end
		cdata_q <= cmem[{p_q[1:0], i_q[3:0]}];
		if (state_q == efpb_pkg::S_BWAIT && brsp.done) begin
			blend_q[i_q[3:0]] <= brsp.blend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efpb_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			efpb_pkg::S_IDLE: begin
				if (accept && opcode == efpb_pkg::OP_EVALUATE) begin
					state_d = (ni == 5'd0) ? efpb_pkg::S_PSTART : efpb_pkg::S_BREQ;
				end
			end
			efpb_pkg::S_BREQ: state_d = efpb_pkg::S_BWAIT;
			efpb_pkg::S_BWAIT: begin
				if (brsp.done) begin
					state_d = (i_q + 5'd1 == ni) ? efpb_pkg::S_PSTART : efpb_pkg::S_BREQ;
				end
			end
			efpb_pkg::S_PSTART: state_d = (ni == 5'd0) ? efpb_pkg::S_POUT : efpb_pkg::S_PRD;
			efpb_pkg::S_PRD:    state_d = efpb_pkg::S_PMUL;
			efpb_pkg::S_PMUL:   state_d = efpb_pkg::S_PACC;
			efpb_pkg::S_PACC:   state_d = (i_q + 5'd1 == ni) ? efpb_pkg::S_POUT : efpb_pkg::S_PRD;
			efpb_pkg::S_POUT: begin
				if (out_free) begin
					state_d = (p_q + 3'd1 == np) ? efpb_pkg::S_IDLE : efpb_pkg::S_PSTART;
				end
			end
			default: state_d = efpb_pkg::S_IDLE;
		endcase
	end

	// sequencer counters (accumulator below)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= 5'd0;
			p_q <= 3'd0;
		end else begin
			case (state_q)
				efpb_pkg::S_IDLE: begin
					i_q <= 5'd0;
					p_q <= 3'd0;
				end
				efpb_pkg::S_BWAIT: begin
					if (brsp.done) begin
						i_q <= i_q + 5'd1;
					end
				end
				efpb_pkg::S_PSTART: i_q <= 5'd0;
				efpb_pkg::S_PACC:   i_q <= i_q + 5'd1;
				efpb_pkg::S_POUT: begin
					if (out_free) begin
						p_q <= p_q + 3'd1;
					end
				end
				default: i_q <= i_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			efpb_pkg::S_PSTART: sum_q <= 38'(signed'(base_q[p_q[1:0]]));
			efpb_pkg::S_PMUL:   prod_q <= signed'(cdata_q) * signed'({1'b0, blend_q[i_q[3:0]]});
			efpb_pkg::S_PACC:   sum_q <= sum_q + 38'(term);
			default: sum_q <= sum_q;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (state_q == efpb_pkg::S_POUT && out_free) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == efpb_pkg::S_POUT && out_free) begin
			profile_number <= p_q[1:0];
			profile_value  <= sat;
			last_result    <= (p_q + 3'd1 == np);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		brsp.done |-> state_q == efpb_pkg::S_BWAIT)
		else $error("blend done outside wait");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == efpb_pkg::S_POUT && out_free && p_q + 3'd1 == np)
		|=> result_valid && last_result && state_q == efpb_pkg::S_IDLE)
		else $error("final profile not flagged");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == efpb_pkg::OP_EVALUATE) |=> !item_ready)
		else $error("ready during evaluate");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != efpb_pkg::S_IDLE) |-> (p_q < np))
		else $error("profile count overrun");

endmodule

// ===== bench/error_function_profile_builder_tb.sv =====
// ----------------------------------------------------------------------------
// error_function_profile_builder_tb
// Self-checking bench for the smoothed-step profile builder: loads, then
// evaluates under several register settings, each result checked against a
// local Q16.16 / Q2.30 model of the step blends and saturated sums.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module error_function_profile_builder_tb;

	localparam int  PHI_SPAN   = 6;
	localparam int  PHI_POINTS = 256;
	localparam longint ONE_Q30 = 64'sd1 << 30;
	localparam longint LIMIT   = 2_000_000;

	typedef struct {
		efpb_pkg::opcode_t  op;
		logic [3:0]         iface;
		logic [1:0]         prof;
		logic signed [31:0] val;
		logic signed [31:0] rough;
	} item_t;

	typedef struct {
		logic [1:0]         num;
		logic signed [31:0] value;
		logic               last;
	} profile_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	efpb_pkg::reg_index_t cfg_index = efpb_pkg::REG_NUM_INTERFACES;
	logic [4:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_ready;
	logic [1:0] opcode = '0;
	logic [3:0] interface_index = '0;
	logic [1:0] profile_index = '0;
	logic signed [31:0] position_or_value = '0;
	logic signed [31:0] roughness_value = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [1:0] profile_number;
	logic signed [31:0] profile_value;
	logic last_result;

	item_t        pending_items[$];
	profile_out_t expected_profiles[$];
	longint       phi_table[0:PHI_POINTS];
	longint       offsets[16], roughs[16], contrasts[4][16], bases[4];
	int           iface_count = 0;
	int           profile_count = 1;
	bit           steady = 1'b0;
	bit           in_taken = 1'b0;
	int           failures = 0;
	longint       cycles = 0;

	error_function_profile_builder dut (.*);

	always #1 clk = ~clk;

	function automatic longint mulq(longint a, longint b);
		return (a * b + (64'sd1 << 29)) >>> 30;
	endfunction

	function automatic void build_phi_table();
		longint s, x, x2, r, r2, w, g0, g1, g2, q, acc;
		s   = (longint'(PHI_SPAN) << 30) / (2 * PHI_POINTS);
		x   = (s * s) >>> 31;
		x2  = (x * x) >>> 30;
		r   = ONE_Q30 - x + (x2 >>> 1) - ((x2 * x) >>> 30) / 6;
		r2  = mulq(r, r);
		w   = (longint'(428361012) * PHI_SPAN) / (6 * PHI_POINTS);
		g0  = ONE_Q30;
		q   = r;
		acc = ONE_Q30 / 2;
		phi_table[0] = acc;
		for (int k = 0; k < PHI_POINTS; k++) begin
			g1  = mulq(g0, q);
			q   = mulq(q, r2);
			g2  = mulq(g1, q);
			q   = mulq(q, r2);
			acc = acc + (((g0 + 4 * g1 + g2) * w + (64'sd1 << 29)) >>> 30);
			if (acc > ONE_Q30) begin
				acc = ONE_Q30;
			end
			phi_table[k + 1] = acc;
			g0 = g2;
		end
	endfunction

	function automatic longint step_blend(longint z, longint off, longint rough);
		longint den, t, a, u, idx, rem, v;
		den = longint'(PHI_SPAN) << 16;
		if (rough <= 0) begin
			return (z >= off) ? ONE_Q30 : 0;
		end
		t = ((z - off) * 65536) / rough;
		a = (t < 0) ? -t : t;
		if (a >= den) begin
			return (t > 0) ? ONE_Q30 : 0;
		end
		u   = a * PHI_POINTS;
		idx = u / den;
		rem = u % den;
		v   = phi_table[idx] + ((phi_table[idx + 1] - phi_table[idx]) * rem) / den;
		return (t < 0) ? ONE_Q30 - v : v;
	endfunction

	// update the stores or queue the profile values for one transfer
	function automatic void apply_item(item_t it);
		longint blends[16];
		longint sum;
		int ni, np;
		profile_out_t e;
		case (it.op)
			efpb_pkg::OP_LOAD_IFACE: begin
				offsets[it.iface] = it.val;
				roughs[it.iface]  = it.rough;
			end
			efpb_pkg::OP_LOAD_CONTRAST: contrasts[it.prof][it.iface] = it.val;
			efpb_pkg::OP_LOAD_BASE:     bases[it.prof] = it.val;
			default: begin
				ni = (iface_count > efpb_pkg::MAX_INTERFACES) ?
					efpb_pkg::MAX_INTERFACES : iface_count;
				np = (profile_count == 0) ? 1 : profile_count;
				if (np > efpb_pkg::MAX_PROFILES) begin
					np = efpb_pkg::MAX_PROFILES;
				end
				for (int i = 0; i < ni; i++) begin
					blends[i] = step_blend(it.val, offsets[i], roughs[i]);
				end
				for (int p = 0; p < np; p++) begin
					sum = bases[p];
					for (int i = 0; i < ni; i++) begin
						sum += (contrasts[p][i] * blends[i] + (64'sd1 << 29)) >>> 30;
					end
					if (sum > 64'sd2147483647) begin
						sum = 64'sd2147483647;
					end
					if (sum < -64'sd2147483648) begin
						sum = -64'sd2147483648;
					end
					e.num   = p[1:0];
					e.value = sum[31:0];
					e.last  = (p + 1 == np);
					expected_profiles.push_back(e);
				end
			end
		endcase
	endfunction

	// sender
	always @(negedge clk) begin
		if (!item_valid || in_taken) begin
			if (pending_items.size() > 0 && arst_n && (steady || $urandom_range(0, 99) >= 28)) begin
				item_valid        <= 1'b1;
				opcode            <= pending_items[0].op;
				interface_index   <= pending_items[0].iface;
				profile_index     <= pending_items[0].prof;
				position_or_value <= pending_items[0].val;
				roughness_value   <= pending_items[0].rough;
			end else begin
				item_valid <= 1'b0;
			end
		end
		result_ready <= arst_n && (steady || $urandom_range(0, 99) >= 28);
	end

	// item transfer and result check
	always @(posedge clk) begin
		profile_out_t e;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		in_taken <= item_valid && item_ready;
		if (item_valid && item_ready) begin
			apply_item(pending_items.pop_front());
		end
		if (result_valid && result_ready) begin
			if (expected_profiles.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("unexpected result %0d %0d %0b", profile_number,
						profile_value, last_result);
				end
			end else begin
				e = expected_profiles.pop_front();
				if (e.num !== profile_number || e.value !== profile_value ||
					e.last !== last_result) begin
					failures++;
					if (failures <= 10) begin
						$display("mismatch: expected %0d %0d %0b, got %0d %0d %0b",
							e.num, e.value, e.last,
							profile_number, profile_value, last_result);
					end
				end
			end
		end
	end

	task automatic drain();
		wait (pending_items.size() == 0 && expected_profiles.size() == 0);
		@(negedge clk);
		wait (!item_valid && expected_profiles.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(efpb_pkg::reg_index_t idx, logic [4:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == efpb_pkg::REG_NUM_INTERFACES) begin
			iface_count = data;
		end else begin
			profile_count = data[2:0];
		end
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic item_t make_item(efpb_pkg::opcode_t op, int iface, int prof,
		logic signed [31:0] val, logic signed [31:0] rough);
		item_t it;
		it.op = op;
		it.iface = iface[3:0];
		it.prof = prof[1:0];
		it.val = val;
		it.rough = rough;
		return it;
	endfunction

	function automatic logic signed [31:0] rand_q(int span);
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff};
			default: return $signed($urandom_range(0, 2 * span)) - span;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_rough();
		case ($urandom_range(0, 7))
			0: return -$signed($urandom_range(0, 32'h0010_0000));
			1: return 0;
			2: return $urandom;
			3: return $urandom_range(1, 16);
			default: return $urandom_range(1, 32'h0002_0000);
		endcase
	endfunction

	function automatic void queue_random(int n);
		int op;
		for (int k = 0; k < n; k++) begin
			op = $urandom_range(0, 9);
			if (op < 2) begin
				pending_items.push_back(make_item(efpb_pkg::OP_LOAD_IFACE,
					$urandom_range(0, 15), $urandom_range(0, 3),
					rand_q(32'h000a_0000), rand_rough()));
			end else if (op < 3) begin
				pending_items.push_back(make_item(efpb_pkg::OP_LOAD_CONTRAST,
					$urandom_range(0, 15), $urandom_range(0, 3), rand_q(32'h0040_0000),
					$urandom));
			end else if (op < 4) begin
				pending_items.push_back(make_item(efpb_pkg::OP_LOAD_BASE,
					$urandom_range(0, 15), $urandom_range(0, 3),
					rand_q(32'h0040_0000), $urandom));
			end else begin
				pending_items.push_back(make_item(efpb_pkg::OP_EVALUATE,
					$urandom_range(0, 15), $urandom_range(0, 3),
					rand_q(32'h000f_0000), $urandom));
			end
		end
	endfunction

	initial begin
		build_phi_table();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill every store before any evaluation
		for (int i = 0; i < 16; i++) begin
			pending_items.push_back(make_item(efpb_pkg::OP_LOAD_IFACE, i, 0,
				$signed(i - 8) <<< 16, (i % 4 == 0) ? 32'sd0 : (32'sd1 <<< (12 + i % 6))));
			for (int p = 0; p < 4; p++) begin
				pending_items.push_back(make_item(efpb_pkg::OP_LOAD_CONTRAST, i, p,
					$signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000, 0));
			end
		end
		for (int p = 0; p < 4; p++) begin
			pending_items.push_back(make_item(efpb_pkg::OP_LOAD_BASE, 0, p, p <<< 16, 0));
		end
		drain();

		// default registers: base value only
		pending_items.push_back(make_item(efpb_pkg::OP_EVALUATE, 0, 0, 32'sh7fff_ffff, 0));
		drain();

		write_reg(efpb_pkg::REG_NUM_INTERFACES, 5'd16);
		write_reg(efpb_pkg::REG_NUM_PROFILES, 5'd4);
		steady = 1'b1;
		pending_items.push_back(make_item(efpb_pkg::OP_EVALUATE, 0, 0, 32'sh8000_0000, 0));
		pending_items.push_back(make_item(efpb_pkg::OP_EVALUATE, 0, 0, 32'sh7fff_ffff, 0));
		pending_items.push_back(make_item(efpb_pkg::OP_EVALUATE, 0, 0, 32'sh0000_0000, 0));
		pending_items.push_back(make_item(efpb_pkg::OP_EVALUATE, 0, 0, -32'sh0000_8000, 0));
		// sharp steps at offset exactly, tiny and huge roughness, negative roughness
		pending_items.push_back(make_item(efpb_pkg::OP_LOAD_IFACE, 1, 0,
			32'sh0001_0000, 32'sh0000_0001));
		pending_items.push_back(make_item(efpb_pkg::OP_LOAD_IFACE, 2, 0,
			32'sh0001_0000, 32'sh7fff_ffff));
		pending_items.push_back(make_item(efpb_pkg::OP_LOAD_IFACE, 3, 0,
			32'sh0001_0000, -32'sh0001_0000));
		pending_items.push_back(make_item(efpb_pkg::OP_LOAD_CONTRAST, 1, 0, 32'sh7fff_ffff, 0));
		pending_items.push_back(make_item(efpb_pkg::OP_LOAD_CONTRAST, 2, 0, 32'sh7fff_ffff, 0));
		pending_items.push_back(make_item(efpb_pkg::OP_LOAD_CONTRAST, 3, 1, 32'sh8000_0000, 0));
		pending_items.push_back(make_item(efpb_pkg::OP_LOAD_BASE, 0, 3, 32'sh8000_0000, 0));
		pending_items.push_back(make_item(efpb_pkg::OP_LOAD_BASE, 0, 0, 32'sh7fff_ffff, 0));
		pending_items.push_back(make_item(efpb_pkg::OP_EVALUATE, 0, 0, 32'sh0001_0000, 0));
		pending_items.push_back(make_item(efpb_pkg::OP_EVALUATE, 0, 0, 32'sh0000_ffff, 0));
		pending_items.push_back(make_item(efpb_pkg::OP_EVALUATE, 0, 0, 32'sh0006_0000, 0));
		pending_items.push_back(make_item(efpb_pkg::OP_EVALUATE, 0, 0, -32'sh0005_0000, 0));
		drain();
		steady = 1'b0;

		// above-range and zero register values
		write_reg(efpb_pkg::REG_NUM_INTERFACES, 5'd31);
		write_reg(efpb_pkg::REG_NUM_PROFILES, 5'd7);
		queue_random(20);
		drain();
		write_reg(efpb_pkg::REG_NUM_INTERFACES, 5'd1);
		write_reg(efpb_pkg::REG_NUM_PROFILES, 5'd0);
		queue_random(20);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(efpb_pkg::REG_NUM_INTERFACES, 5'($urandom_range(0, 31)));
			write_reg(efpb_pkg::REG_NUM_PROFILES, 5'($urandom_range(0, 7)));
			steady = (ph == 2);
			queue_random(20);
			drain();
		end
		steady = 1'b0;

		repeat (100) @(posedge clk);
		if (failures == 0 && expected_profiles.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
